[src/rstg_pkg.sv]
`default_nettype none

package rstg_pkg;

  localparam int CFG_W     = 32;
  localparam int GAIN_W    = 31;
  localparam int FRAMES_W  = 24;
  localparam int MODE_W    = 2;
  localparam int SAMPLE_W  = 16;
  localparam int GAIN_INT_W = 15;

  // configuration register indexes
  localparam logic [1:0] REG_PHASE_STEP  = 2'd0;
  localparam logic [1:0] REG_GAIN_STEP   = 2'd1;
  localparam logic [1:0] REG_CHANNEL_MODE = 2'd2;
  localparam logic [1:0] REG_TONE_FRAMES = 2'd3;

  // channel routing codes, anything else mutes both sides
  localparam logic [MODE_W-1:0] MODE_BOTH  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LEFT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RIGHT = 2'd2;

  typedef struct packed {
    logic                  active;
    logic                  last_frame;
    logic [GAIN_INT_W-1:0] gain_int;
  } rstg_meta_t;

endpackage

`default_nettype wire

[src/ramped_sine_tone_generator_unit.sv]
`default_nettype none

// Stereo sine test tone by phase accumulation, with a gain that rises
// linearly from zero. Every accepted word (restart flag) yields one output
// word with a left and right sample; the tone runs for tone_frames words
// after a restart and then reads zero with active low. The unit takes one
// word per clock unless out_stall holds the pipeline, and holds four words
// in flight. A word passes the phase, gain and frame counters, which update
// in the same cycle a word is taken, then the registered sine table read,
// the gain multiply register and the output register.
// Register writes are meant to happen only while nothing is in flight.
module ramped_sine_tone_generator_unit #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int PHASE_BITS       = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_write,
  input  wire logic [1:0]                           cfg_index,
  input  wire logic [rstg_pkg::CFG_W-1:0]           cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 restart,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [rstg_pkg::SAMPLE_W-1:0]      left_sample,
  output logic signed [rstg_pkg::SAMPLE_W-1:0]      right_sample,
  output logic                                      active,
  output logic                                      last_frame
);

  localparam int AddrW = $clog2(SINE_TABLE_DEPTH);

  logic [rstg_pkg::CFG_W-1:0]    phase_step;
  logic [rstg_pkg::GAIN_W-1:0]   gain_step;
  logic [rstg_pkg::MODE_W-1:0]   channel_mode;
  logic [rstg_pkg::FRAMES_W-1:0] tone_frames;

  logic                          s1_valid;
  rstg_pkg::rstg_meta_t          s1_meta;
  logic [AddrW-1:0]              s1_index;
  logic                          s2_ready;
  logic signed [rstg_pkg::SAMPLE_W-1:0] sine;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step   <= '0;
      gain_step    <= '0;
      channel_mode <= rstg_pkg::MODE_BOTH;
      tone_frames  <= rstg_pkg::FRAMES_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        rstg_pkg::REG_PHASE_STEP:   phase_step   <= cfg_data;
        rstg_pkg::REG_GAIN_STEP:    gain_step    <= cfg_data[rstg_pkg::GAIN_W-1:0];
        rstg_pkg::REG_CHANNEL_MODE: channel_mode <= cfg_data[rstg_pkg::MODE_W-1:0];
        rstg_pkg::REG_TONE_FRAMES:  tone_frames  <= cfg_data[rstg_pkg::FRAMES_W-1:0];
        default: ;
      endcase
    end
  end

  rstg_tone_ctrl #(
    .PHASE_BITS (PHASE_BITS),
    .DEPTH      (SINE_TABLE_DEPTH),
    .ADDR_W     (AddrW)
  ) u_tone_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .restart     (restart),
    .phase_step  (phase_step),
    .gain_step   (gain_step),
    .tone_frames (tone_frames),
    .s2_ready    (s2_ready),
    .s1_valid    (s1_valid),
    .s1_meta     (s1_meta),
    .s1_index    (s1_index)
  );

  rstg_sine_rom #(
    .DEPTH  (SINE_TABLE_DEPTH),
    .ADDR_W (AddrW)
  ) u_sine_rom (
    .clk  (clk),
    .en   (s2_ready),
    .addr (s1_index),
    .q    (sine)
  );

  rstg_sample_path u_sample_path (
    .clk          (clk),
    .rst          (rst),
    .s1_valid     (s1_valid),
    .s1_meta      (s1_meta),
    .s2_ready     (s2_ready),
    .sine         (sine),
    .channel_mode (channel_mode),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .active       (active),
    .last_frame   (last_frame)
  );

endmodule

`default_nettype wire

[src/rstg_sine_rom.sv]
`default_nettype none

module rstg_sine_rom #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [ADDR_W-1:0]        addr,
  output logic signed [rstg_pkg::SAMPLE_W-1:0] q
);

  localparam logic [63:0] PiQ30     = 64'd3373259426;
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
  localparam logic [63:0] TwoPiQ30  = 64'd6746518852;

  // q30 taylor series through x^17, evaluated at elaboration only
  function automatic logic signed [rstg_pkg::SAMPLE_W-1:0] sine_entry(input logic [63:0] k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [63:0] s;
    logic               neg;
    x = (k * TwoPiQ30) / 64'(DEPTH);
    neg = 1'b0;
    if (x >= PiQ30) begin
      neg = 1'b1;
      x = x - PiQ30;
    end
    if (x > HalfPiQ30) begin
      x = PiQ30 - x;
    end
    x2 = (x * x) >> 30;
    s = signed'(x);
    term = x;
    for (int n = 1; n <= 8; n++) begin
      term = (term * x2) >> 30;
      case (n)
        1: term = term / 64'd6;
        2: term = term / 64'd20;
        3: term = term / 64'd42;
        4: term = term / 64'd72;
        5: term = term / 64'd110;
        6: term = term / 64'd156;
        7: term = term / 64'd210;
        default: term = term / 64'd272;
      endcase
      if (n[0]) begin
        s = s - signed'(term);
      end else begin
        s = s + signed'(term);
      end
    end
    if (s < 0) begin
      s = '0;
    end
    v = (unsigned'(s) * 64'd32767 + 64'd536870912) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return neg ? -signed'(v[rstg_pkg::SAMPLE_W-1:0]) : signed'(v[rstg_pkg::SAMPLE_W-1:0]);
  endfunction

  logic signed [rstg_pkg::SAMPLE_W-1:0] rom [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_rom
    assign rom[k] = sine_entry(64'(k));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= rom[addr];
    end
  end

endmodule

`default_nettype wire

[src/rstg_tone_ctrl.sv]
`default_nettype none

module rstg_tone_ctrl #(
  parameter int PHASE_BITS = 32,
  parameter int DEPTH      = 1024,
  parameter int ADDR_W     = 10
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               restart,
  input  wire logic [rstg_pkg::CFG_W-1:0]         phase_step,
  input  wire logic [rstg_pkg::GAIN_W-1:0]        gain_step,
  input  wire logic [rstg_pkg::FRAMES_W-1:0]      tone_frames,
  input  wire logic                               s2_ready,
  output logic                                    s1_valid,
  output rstg_pkg::rstg_meta_t                    s1_meta,
  output logic [ADDR_W-1:0]                       s1_index
);

  localparam int SumW = (PHASE_BITS > rstg_pkg::CFG_W) ? PHASE_BITS : rstg_pkg::CFG_W;
  localparam int ScaleW = PHASE_BITS + ADDR_W;
  localparam logic [rstg_pkg::GAIN_W-1:0] GainCeil = 31'h7FFF0000;

  logic [PHASE_BITS-1:0]            phase_acc;
  logic [rstg_pkg::GAIN_W-1:0]      gain_acc;
  logic [rstg_pkg::FRAMES_W-1:0]    frames_done;

  logic                             ready;
  logic                             accept;
  logic [PHASE_BITS-1:0]            base_phase;
  logic [rstg_pkg::GAIN_W-1:0]      base_gain;
  logic [rstg_pkg::FRAMES_W-1:0]    base_frames;
  logic                             tone_on;
  logic [SumW-1:0]                  phase_sum;
  logic [PHASE_BITS-1:0]            phase_next;
  logic [rstg_pkg::GAIN_W:0]        gain_sum;
  logic [rstg_pkg::GAIN_W-1:0]      gain_next;
  logic [rstg_pkg::FRAMES_W-1:0]    frames_next;
  logic [ScaleW-1:0]                scaled;

  assign ready    = !s1_valid || s2_ready;
  assign in_stall = !ready;
  assign accept   = in_valid && ready;

  // restart clears the state before this word is looked at
  assign base_phase  = restart ? '0 : phase_acc;
  assign base_gain   = restart ? '0 : gain_acc;
  assign base_frames = restart ? '0 : frames_done;
  assign tone_on     = base_frames < tone_frames;

  assign phase_sum   = SumW'(base_phase) + SumW'(phase_step);
  assign phase_next  = phase_sum[PHASE_BITS-1:0];
  assign gain_sum    = {1'b0, base_gain} + {1'b0, gain_step};
  assign gain_next   = (gain_sum > {1'b0, GainCeil}) ? GainCeil
                                                    : gain_sum[rstg_pkg::GAIN_W-1:0];
  assign frames_next = base_frames + rstg_pkg::FRAMES_W'(1);

  // table index is the top bits of phase scaled by the table depth
  assign scaled = ScaleW'(phase_next) * ScaleW'(DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc   <= '0;
      gain_acc    <= '0;
      frames_done <= '0;
      s1_valid    <= 1'b0;
    end else begin
      if (accept) begin
        phase_acc   <= tone_on ? phase_next : base_phase;
        gain_acc    <= tone_on ? gain_next : base_gain;
        frames_done <= tone_on ? frames_next : base_frames;
      end
      if (ready) begin
        s1_valid <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meta.active     <= tone_on;
      s1_meta.last_frame <= tone_on && (frames_next == tone_frames);
      s1_meta.gain_int   <= gain_next[rstg_pkg::GAIN_W-1 -: rstg_pkg::GAIN_INT_W];
      s1_index           <= scaled[ScaleW-1 -: ADDR_W];
    end
  end

endmodule

`default_nettype wire

[src/rstg_sample_path.sv]
`default_nettype none

module rstg_sample_path (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  s1_valid,
  input  wire rstg_pkg::rstg_meta_t                  s1_meta,
  output logic                                       s2_ready,
  input  wire logic signed [rstg_pkg::SAMPLE_W-1:0]  sine,
  input  wire logic [rstg_pkg::MODE_W-1:0]           channel_mode,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [rstg_pkg::SAMPLE_W-1:0]       left_sample,
  output logic signed [rstg_pkg::SAMPLE_W-1:0]       right_sample,
  output logic                                       active,
  output logic                                       last_frame
);

  localparam int ProdW = 2 * rstg_pkg::SAMPLE_W;

  logic                                 s2_valid;
  rstg_pkg::rstg_meta_t                 s2_meta;
  logic                                 s3_valid;
  rstg_pkg::rstg_meta_t                 s3_meta;
  logic signed [ProdW-2:0]              s3_prod;

  logic                                 s3_ready;
  logic                                 out_ready;
  logic signed [ProdW-1:0]              mul;
  logic signed [rstg_pkg::SAMPLE_W-1:0] sample;
  logic                                 to_left;
  logic                                 to_right;

  assign out_ready = !out_valid || !out_stall;
  assign s3_ready  = !s3_valid || out_ready;
  assign s2_ready  = !s2_valid || s3_ready;

  assign mul = ProdW'(sine) * ProdW'(signed'({1'b0, s2_meta.gain_int}));
  // |product| < 2^30, so the floor shift always fits 16 bits
  assign sample = s3_prod[ProdW-2 -: rstg_pkg::SAMPLE_W];

  assign to_left  = (channel_mode == rstg_pkg::MODE_BOTH) || (channel_mode == rstg_pkg::MODE_LEFT);
  assign to_right = (channel_mode == rstg_pkg::MODE_BOTH) || (channel_mode == rstg_pkg::MODE_RIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (s3_ready) begin
        s3_valid <= s2_valid;
      end
      if (out_ready) begin
        out_valid <= s3_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_meta <= s1_meta;
    end
    if (s3_ready) begin
      s3_meta <= s2_meta;
      s3_prod <= mul[ProdW-2:0];
    end
    if (out_ready) begin
      left_sample  <= (s3_meta.active && to_left) ? sample : '0;
      right_sample <= (s3_meta.active && to_right) ? sample : '0;
      active       <= s3_meta.active;
      last_frame   <= s3_meta.last_frame;
    end
  end

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;

  localparam int TABLE_DEPTH = 1024;
  localparam int PHASE_W = 32;
  localparam int LATENCY = 4;
  localparam int RANDOM_ITEMS = 1880;
  localparam logic [rstg_pkg::MODE_W-1:0] MODE_MUTE = 2'd3;

  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
  localparam logic [31:0] GAIN_CEIL = 32'h7FFF_0000;

  typedef struct packed {
    logic signed [rstg_pkg::SAMPLE_W-1:0] left;
    logic signed [rstg_pkg::SAMPLE_W-1:0] right;
    logic active;
    logic last;
  } tone_frame_t;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [1:0] cfg_index;
  logic [rstg_pkg::CFG_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic restart;
  logic out_valid;
  logic out_stall;
  logic signed [rstg_pkg::SAMPLE_W-1:0] left_sample;
  logic signed [rstg_pkg::SAMPLE_W-1:0] right_sample;
  logic active;
  logic last_frame;

  ramped_sine_tone_generator_unit #(
    .SINE_TABLE_DEPTH(TABLE_DEPTH),
    .PHASE_BITS(PHASE_W)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .restart(restart),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .left_sample(left_sample),
    .right_sample(right_sample),
    .active(active),
    .last_frame(last_frame)
  );

  // tone generator copy: table, settings and running state
  int sine_lut[TABLE_DEPTH];
  logic [31:0] cfg_phase_step;
  logic [30:0] cfg_gain_step;
  logic [rstg_pkg::MODE_W-1:0] cfg_mode;
  logic [rstg_pkg::FRAMES_W-1:0] cfg_tone_frames;
  logic [31:0] acc_phase;
  logic [31:0] acc_gain;
  logic [rstg_pkg::FRAMES_W-1:0] frames_played;

  tone_frame_t pending_frames[$];
  int errors = 0;
  int tx_gap_max = 16;
  int rx_gap_max = 16;
  int hold_request = 0;
  int random_sent = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // integer Q30 sine with a Taylor series, quarter-wave folded
  function automatic int sine_entry(input int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned v;
    longint s;
    bit neg;
    x = (64'(k) * TWO_PI_Q30) / 64'(TABLE_DEPTH);
    neg = 1'b0;
    if (x >= PI_Q30) begin
      neg = 1'b1;
      x -= PI_Q30;
    end
    if (x > HALF_PI_Q30) x = PI_Q30 - x;
    x2 = (x * x) >> 30;
    s = longint'(x);
    term = x;
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) s -= longint'(term);
      else s += longint'(term);
    end
    if (s < 0) s = 0;
    v = (64'(s) * 64'd32767 + 64'd536870912) >> 30;
    if (v > 64'd32767) v = 64'd32767;
    return neg ? -int'(v) : int'(v);
  endfunction

  function automatic tone_frame_t next_frame(input logic rs);
    tone_frame_t f;
    logic [32:0] gain_sum;
    logic [9:0] idx;
    longint prod;
    longint smp;
    logic signed [rstg_pkg::SAMPLE_W-1:0] s16;
    f = '0;
    if (rs) begin
      acc_phase = '0;
      acc_gain = '0;
      frames_played = '0;
    end
    if (frames_played >= cfg_tone_frames) return f;
    acc_phase = acc_phase + cfg_phase_step;
    gain_sum = {1'b0, acc_gain} + {2'b0, cfg_gain_step};
    acc_gain = (gain_sum > {1'b0, GAIN_CEIL}) ? GAIN_CEIL : gain_sum[31:0];
    idx = acc_phase[31:22];
    prod = longint'(sine_lut[idx]) * longint'(acc_gain[31:16]);
    // arithmetic shift gives the floor for negative products
    smp = prod >>> 15;
    if (smp > 32767) smp = 32767;
    if (smp < -32768) smp = -32768;
    s16 = smp[15:0];
    f.left = (cfg_mode == rstg_pkg::MODE_BOTH || cfg_mode == rstg_pkg::MODE_LEFT) ? s16 : '0;
    f.right = (cfg_mode == rstg_pkg::MODE_BOTH || cfg_mode == rstg_pkg::MODE_RIGHT) ? s16 : '0;
    f.active = 1'b1;
    f.last = ({1'b0, frames_played} + 25'd1 == {1'b0, cfg_tone_frames});
    frames_played = frames_played + rstg_pkg::FRAMES_W'(1);
    return f;
  endfunction

  // receiver: random stalls per word, or one long hold-off on request
  initial begin : receiver
    int n;
    out_stall = 1'b0;
    forever begin
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
      end else begin
        n = $urandom_range(0, rx_gap_max);
      end
      if (n > 0) begin
        @(negedge clk) out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end
      @(negedge clk) out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : word_check
    tone_frame_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_frames.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected word: L=%0d R=%0d act=%0b last=%0b",
                   left_sample, right_sample, active, last_frame);
      end else begin
        e = pending_frames.pop_front();
        if (left_sample !== e.left || right_sample !== e.right ||
            active !== e.active || last_frame !== e.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp L=%0d R=%0d act=%0b last=%0b, got L=%0d R=%0d act=%0b last=%0b",
                     $signed(e.left), $signed(e.right), e.active, e.last,
                     left_sample, right_sample, active, last_frame);
        end
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [rstg_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      rstg_pkg::REG_PHASE_STEP: cfg_phase_step = data;
      rstg_pkg::REG_GAIN_STEP: cfg_gain_step = data[30:0];
      rstg_pkg::REG_CHANNEL_MODE: cfg_mode = data[rstg_pkg::MODE_W-1:0];
      rstg_pkg::REG_TONE_FRAMES: cfg_tone_frames = data[rstg_pkg::FRAMES_W-1:0];
      default: ;
    endcase
    @(negedge clk) cfg_write <= 1'b0;
  endtask

  task automatic set_tone(input logic [31:0] ph, input logic [30:0] gs,
                          input logic [rstg_pkg::MODE_W-1:0] mode,
                          input logic [rstg_pkg::FRAMES_W-1:0] len);
    write_reg(rstg_pkg::REG_PHASE_STEP, ph);
    write_reg(rstg_pkg::REG_GAIN_STEP, {1'b0, gs});
    write_reg(rstg_pkg::REG_CHANNEL_MODE, {30'b0, mode});
    write_reg(rstg_pkg::REG_TONE_FRAMES, {8'b0, len});
  endtask

  // valid stays high after acceptance until the next falling edge
  task automatic send_frame(input logic rs);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
      restart <= 1'($urandom_range(0, 1));
    end
    @(negedge clk);
    in_valid <= 1'b1;
    restart <= rs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_frames.push_back(next_frame(rs));
  endtask

  task automatic wait_drained();
    @(negedge clk) in_valid <= 1'b0;
    while (pending_frames.size() > 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic test_power_on_defaults();
    // one-frame tone at zero gain, then silence
    send_frame(1'b0);
    send_frame(1'b0);
    wait_drained();
  endtask

  task automatic test_extreme_settings();
    // phase wraps on every frame after the first, gain hits the ceiling at once
    set_tone(32'hFFFF_FFFF, 31'h7FFF_FFFF, rstg_pkg::MODE_BOTH, 24'hFF_FFFF);
    send_frame(1'b1);
    repeat (4) send_frame(1'b0);
    wait_drained();
  endtask

  task automatic test_channel_routing();
    logic [rstg_pkg::MODE_W-1:0] modes[3];
    modes = '{rstg_pkg::MODE_LEFT, rstg_pkg::MODE_RIGHT, MODE_MUTE};
    set_tone(32'h4000_0000, 31'h7FFF_FFFF, rstg_pkg::MODE_BOTH, 24'd50);
    foreach (modes[i]) begin
      write_reg(rstg_pkg::REG_CHANNEL_MODE, {30'b0, modes[i]});
      send_frame(1'b1);
      send_frame(1'b0);
      wait_drained();
    end
  endtask

  task automatic test_tone_end();
    set_tone(32'h0123_4567, 31'h0001_8000, rstg_pkg::MODE_BOTH, 24'd3);
    send_frame(1'b1);
    repeat (3) send_frame(1'b0);
    wait_drained();
  endtask

  task automatic test_zero_length();
    write_reg(rstg_pkg::REG_TONE_FRAMES, '0);
    send_frame(1'b1);
    send_frame(1'b0);
    wait_drained();
  endtask

  task automatic test_backpressure();
    set_tone(32'h0345_6789, 31'h0040_0000, rstg_pkg::MODE_BOTH, 24'd1000);
    tx_gap_max = 0;
    hold_request = 300;
    send_frame(1'b1);
    repeat (39) send_frame(1'b0);
    wait_drained();
    tx_gap_max = 16;
  endtask

  task automatic test_random_tones();
    int pick;
    int len;
    int kind;
    int phase_sent;
    int phase_items;
    int span[3];
    logic [31:0] ph;
    logic [30:0] gs;
    logic [rstg_pkg::FRAMES_W-1:0] tl;
    span = '{0, 2, 16};
    while (random_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 2);
      ph = (pick == 0) ? $urandom : (pick == 1) ? $urandom_range(0, 32'h0100_0000) : 32'h0;
      case ($urandom_range(0, 3))
        0: gs = 31'($urandom);
        1: gs = 31'($urandom_range(1, 32'h0200_0000));
        2: gs = '0;
        default: gs = 31'h7FFF_FFFF;
      endcase
      case ($urandom_range(0, 3))
        0: tl = 24'($urandom_range(1, 64));
        1: tl = 24'($urandom_range(0, 8));
        2: tl = 24'hFF_FFFF;
        default: tl = 24'($urandom_range(1, 24'hFF_FFFF));
      endcase
      set_tone(ph, gs, 2'($urandom_range(0, 3)), tl);
      tx_gap_max = span[$urandom_range(0, 2)];
      rx_gap_max = span[$urandom_range(0, 2)];
      phase_items = $urandom_range(80, 200);
      phase_sent = 0;
      while (phase_sent < phase_items) begin
        kind = $urandom_range(0, 7);
        if (kind == 0) begin
          // noise: restart at random
          len = $urandom_range(1, 12);
          repeat (len) send_frame(1'($urandom_range(0, 1)));
        end else begin
          // a tone from restart, sometimes cut short by a stray restart
          len = (cfg_tone_frames <= 64) ? $urandom_range(1, cfg_tone_frames + 6)
                                        : $urandom_range(1, 80);
          for (int i = 0; i < len; i++)
            send_frame(i == 0 || (kind == 1 && $urandom_range(0, 9) == 0));
        end
        phase_sent += len;
      end
      random_sent += phase_sent;
      wait_drained();
    end
    tx_gap_max = 16;
    rx_gap_max = 16;
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = rstg_pkg::REG_PHASE_STEP;
    cfg_data = '0;
    in_valid = 1'b0;
    restart = 1'b0;
    for (int k = 0; k < TABLE_DEPTH; k++) sine_lut[k] = sine_entry(k);
    cfg_phase_step = '0;
    cfg_gain_step = '0;
    cfg_mode = rstg_pkg::MODE_BOTH;
    cfg_tone_frames = 24'd1;
    acc_phase = '0;
    acc_gain = '0;
    frames_played = '0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_power_on_defaults();
    test_extreme_settings();
    test_channel_routing();
    test_tone_end();
    test_zero_length();
    test_backpressure();
    test_random_tones();

    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending_frames.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
